[rtl/core/crpf_pkg.sv]
// Package for the Catmull-Rom path follower core: widths, fixed-point constants,
// path offset table, saturation helper and the coefficient bundle type.
// Depends on nothing; imported by crpf_coef and catmull_rom_path_follower_core.
`default_nettype none

package crpf_pkg;

	// fraction precision of the segment position (unsigned Q1.FRAC_BITS)
	localparam int FRAC_BITS = 16;

	localparam int COORD_W  = 32;
	localparam int SPEED_W  = 24;
	localparam int DT_W     = 16;
	localparam int NUM_PTS  = 8;
	localparam int SEG_W    = $clog2(NUM_PTS);
	localparam int AXIS_W   = 2;
	localparam int NUM_AXES = 3;
	localparam int NUM_EVAL = 2 * NUM_AXES;
	localparam int EV_W     = $clog2(NUM_EVAL);

	localparam int FRAC_W = FRAC_BITS + 1;
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
	localparam logic [FRAC_W-1:0] LOOK_STEP =
		FRAC_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	localparam logic [SEG_W-1:0] FIRST_SEG = SEG_W'(1);
	localparam logic [SEG_W-1:0] LAST_SEG  = SEG_W'(NUM_PTS - 3);

	// cubic accumulator: wide enough for every intermediate of the Horner chain
	localparam int ACC_W  = 40;
	localparam int MB_W   = (FRAC_BITS + 2 > DT_W + 1) ? FRAC_BITS + 2 : DT_W + 1;
	localparam int PROD_W = ACC_W + MB_W;

	// speed * delta_time is Q8.32; keep FRAC_BITS fraction bits
	localparam int PROD_FRAC = 2 * DT_W;
	localparam int INC_SHIFT = PROD_FRAC - FRAC_BITS;
	localparam int INC_W     = SPEED_W + DT_W - INC_SHIFT;
	localparam int TOT_W     = INC_W + 1;
	localparam int WHOLE_W   = TOT_W - FRAC_BITS;
	localparam int SUM_W     = WHOLE_W + 1;

	localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(65536);

	// path offsets are stored in half coordinate units (Q16.16 half = 2^15)
	localparam int HALF_SHIFT = 15;
	localparam int OFF_W      = 21;

	localparam logic signed [ACC_W-1:0] COORD_MAX = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);

	localparam logic OP_ANCHOR = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [AXIS_W-1:0] AX_X = 2'd0;
	localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

	localparam logic signed [4:0] OFFS_HALF [6][3] = '{
		'{-5'sd12,  5'sd6,  5'sd10},
		'{ -5'sd8,  5'sd8,   5'sd2},
		'{  5'sd0, 5'sd10, -5'sd10},
		'{  5'sd8,  5'sd6,  -5'sd4},
		'{ 5'sd12,  5'sd8,   5'sd8},
		'{  5'sd0,  5'sd7,  5'sd12}
	};

	typedef struct packed {
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
		logic signed [ACC_W-1:0] c;
		logic signed [ACC_W-1:0] p1x2;
	} crpf_coef_t;

	// offset of path point pi on one axis; end points repeat their neighbors
	function automatic logic signed [OFF_W-1:0] pt_offset(input logic [SEG_W-1:0] pi,
			input logic [AXIS_W-1:0] axis);
		logic [2:0] row;
		logic signed [4:0] half;
		if (pi == SEG_W'(0)) begin
			row = 3'd0;
		end else if (pi >= SEG_W'(NUM_PTS - 1)) begin
			row = 3'd5;
		end else begin
			row = 3'(pi - SEG_W'(1));
		end
		case (axis)
			AX_X: half = OFFS_HALF[row][0];
			AX_Y: half = OFFS_HALF[row][1];
			AX_Z: half = OFFS_HALF[row][2];
			default: half = 5'sd0;
		endcase
		return OFF_W'(half) <<< HALF_SHIFT;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
		if (v > COORD_MAX) begin
			return COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			return COORD_MIN[COORD_W-1:0];
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

[rtl/core/crpf_coef.sv]
// Control point loader and cubic coefficient former for one axis of one segment.
// Rebuilds the four saturated path points from the anchor, then forms a, b, c, 2*p1.
// Depends on crpf_pkg.
`default_nettype none

module crpf_coef
	import crpf_pkg::*;
(
	input  logic                      clk,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] anchor,
	input  logic [SEG_W-1:0]          seg,
	input  logic [AXIS_W-1:0]         axis,
	output crpf_coef_t                coef
);

	logic signed [COORD_W-1:0] pt_q [4];
	logic signed [ACC_W-1:0]   e0, e1, e2, e3;

	// points seg-1 .. seg+2 around the current segment
	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < 4; j++) begin
				pt_q[j] <= sat_coord(ACC_W'(anchor) +
					ACC_W'(pt_offset(seg - SEG_W'(1) + SEG_W'(j), axis)));
			end
		end
	end

	always_comb begin
		e0 = ACC_W'(pt_q[0]);
		e1 = ACC_W'(pt_q[1]);
		e2 = ACC_W'(pt_q[2]);
		e3 = ACC_W'(pt_q[3]);
		coef.a    = e2 - e0;
		coef.b    = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		coef.c    = (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
		coef.p1x2 = e1 <<< 1;
	end

endmodule

`default_nettype wire

[rtl/core/catmull_rom_path_follower_core.sv]
// Catmull-Rom path follower core: the top level with sequencer, shared multiplier
// and output register. Depends on crpf_pkg and crpf_coef.
//
// An anchor item (opcode 0) builds the path once and returns the start pose; a tick
// item (opcode 1) advances along the path by speed * delta_time and returns the
// position, the look point 0.01 segment ahead and the end flag. Items that make no
// result (ticks before a path exists, anchors after it) are dropped while the block stays ready.
// Each result takes six cubic evaluations, each a load, coefficients, three Horner
// steps through the single 40 x 18 bit multiplier and a write; a done state then
// hands the result to the output register. A moving tick first runs the advance
// (multiply, then carry). in_ready stays low from when an item is taken until the
// block is back in idle, so a new item is not taken while one is in work. A tick at
// the path end skips the advance and takes as long as an anchor.
// The result waits in its own register, so the next item is taken while it is held;
// a finished result waits for that register to empty before the block turns ready.
`default_nettype none

module catmull_rom_path_follower_core
	import crpf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [SPEED_W-1:0]        cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic signed [COORD_W-1:0] anchor_x,
	input  logic signed [COORD_W-1:0] anchor_y,
	input  logic signed [COORD_W-1:0] anchor_z,
	input  logic [DT_W-1:0]           delta_time,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] pos_x,
	output logic signed [COORD_W-1:0] pos_y,
	output logic signed [COORD_W-1:0] pos_z,
	output logic signed [COORD_W-1:0] look_x,
	output logic signed [COORD_W-1:0] look_y,
	output logic signed [COORD_W-1:0] look_z,
	output logic                      at_end
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV_MUL,
		ST_ADV_CARRY,
		ST_LOAD,
		ST_COEF,
		ST_MUL,
		ST_WRITE,
		ST_DONE
	} state_t;

	localparam logic [1:0] MAC_B  = 2'd0;
	localparam logic [1:0] MAC_A  = 2'd1;
	localparam logic [1:0] MAC_P1 = 2'd2;

	state_t                    state_q;
	logic [SPEED_W-1:0]        speed_q;
	logic [SEG_W-1:0]          seg_q;
	logic [FRAC_W-1:0]         frac_q;
	logic                      end_q;
	logic                      built_q;
	logic [EV_W-1:0]           ev_q;
	logic [1:0]                step_q;
	logic                      out_valid_q;

	logic signed [COORD_W-1:0] anchor_q [NUM_AXES];
	logic [DT_W-1:0]           dt_q;
	logic [INC_W-1:0]          inc_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [COORD_W-1:0] res_q [NUM_EVAL];
	logic signed [COORD_W-1:0] out_q [NUM_EVAL];
	logic                      out_end_q;

	logic                      in_acc;
	logic                      take_anchor;
	logic                      take_tick;
	logic                      out_free;
	logic                      is_look;
	logic [EV_W-1:0]           ev_rel;
	logic [AXIS_W-1:0]         axis;
	logic [FRAC_W-1:0]         t_val;
	logic signed [COORD_W-1:0] anchor_sel;
	logic signed [ACC_W-1:0]   mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   mac_sum;
	logic [TOT_W-1:0]          total;
	logic [SUM_W-1:0]          seg_sum;
	logic                      in_path;
	crpf_coef_t                coef;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign take_anchor = in_acc && (opcode == OP_ANCHOR) && !built_q;
	assign take_tick   = in_acc && (opcode == OP_TICK) && built_q;
	assign out_free    = !out_valid_q || out_ready;

	// evaluations 0..2 are the position, 3..5 the look point
	always_comb begin
		is_look = (ev_q >= EV_W'(NUM_AXES));
		ev_rel  = is_look ? ev_q - EV_W'(NUM_AXES) : ev_q;
		axis    = ev_rel[AXIS_W-1:0];
		t_val   = is_look ? frac_q + LOOK_STEP : frac_q;
		case (axis)
			AX_X: anchor_sel = anchor_q[0];
			AX_Y: anchor_sel = anchor_q[1];
			AX_Z: anchor_sel = anchor_q[2];
			default: anchor_sel = anchor_q[0];
		endcase
	end

	crpf_coef u_coef (
		.clk    (clk),
		.load   (state_q == ST_LOAD),
		.anchor (anchor_sel),
		.seg    (seg_q),
		.axis   (axis),
		.coef   (coef)
	);

	// shared multiplier: speed * delta_time during advance, Horner steps otherwise
	always_comb begin
		if (state_q == ST_ADV_MUL) begin
			mul_a = ACC_W'(speed_q);
			mul_b = MB_W'(dt_q);
		end else begin
			mul_a = acc_q;
			mul_b = MB_W'(t_val);
		end
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_sh = prod >>> FRAC_BITS;
		case (step_q)
			MAC_B:   addend = coef.b;
			MAC_A:   addend = coef.a;
			MAC_P1:  addend = coef.p1x2;
			default: addend = coef.p1x2;
		endcase
		mac_sum = ACC_W'(prod_sh) + addend;
	end

	// carry whole segments; past the last segment clamp at its end
	always_comb begin
		total   = TOT_W'(frac_q) + TOT_W'(inc_q);
		seg_sum = SUM_W'(total[TOT_W-1:FRAC_BITS]) + SUM_W'(seg_q);
		in_path = (seg_sum <= SUM_W'(LAST_SEG));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			speed_q     <= SPEED_RST;
			seg_q       <= '0;
			frac_q      <= '0;
			end_q       <= 1'b0;
			built_q     <= 1'b0;
			ev_q        <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				speed_q <= cfg_wdata;
			end
			// a result handed over in the same cycle keeps the output valid
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ev_q <= '0;
					if (take_anchor) begin
						seg_q   <= FIRST_SEG;
						frac_q  <= '0;
						end_q   <= 1'b0;
						built_q <= 1'b1;
						state_q <= ST_LOAD;
					end else if (take_tick) begin
						// at the end there is no motion: repeat the end pose
						state_q <= end_q ? ST_LOAD : ST_ADV_MUL;
					end
				end
				ST_ADV_MUL: begin
					state_q <= ST_ADV_CARRY;
				end
				ST_ADV_CARRY: begin
					if (in_path) begin
						seg_q  <= seg_sum[SEG_W-1:0];
						frac_q <= {1'b0, total[FRAC_BITS-1:0]};
					end else begin
						seg_q  <= LAST_SEG;
						frac_q <= FRAC_ONE;
						end_q  <= 1'b1;
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_COEF;
				end
				ST_COEF: begin
					step_q  <= MAC_B;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == MAC_P1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (ev_q == EV_W'(NUM_EVAL - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ev_q    <= ev_q + EV_W'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_anchor) begin
			anchor_q[0] <= anchor_x;
			anchor_q[1] <= anchor_y;
			anchor_q[2] <= anchor_z;
		end
		if (in_acc) begin
			dt_q <= delta_time;
		end
		if (state_q == ST_ADV_MUL) begin
			inc_q <= prod[INC_SHIFT +: INC_W];
		end
		if (state_q == ST_COEF) begin
			acc_q <= coef.c;
		end else if (state_q == ST_MUL) begin
			acc_q <= mac_sum;
		end
		if (state_q == ST_WRITE) begin
			res_q[ev_q] <= sat_coord(acc_q >>> 1);
		end
		if (state_q == ST_DONE && out_free) begin
			for (int i = 0; i < NUM_EVAL; i++) begin
				out_q[i] <= res_q[i];
			end
			out_end_q <= end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_q[0];
	assign pos_y     = out_q[1];
	assign pos_z     = out_q[2];
	assign look_x    = out_q[3];
	assign look_y    = out_q[4];
	assign look_z    = out_q[5];
	assign at_end    = out_end_q;

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> (seg_q >= FIRST_SEG && seg_q <= LAST_SEG))
		else $error("segment index left the path");

	a_end_pose: assert property (@(posedge clk) disable iff (!arst_n)
		end_q |-> (frac_q == FRAC_ONE && seg_q == LAST_SEG))
		else $error("end flag without clamped pose");

	a_frac_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		!end_q |-> (frac_q < FRAC_ONE))
		else $error("fraction reached one while moving");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		!built_q |-> !out_valid_q)
		else $error("result item before a path exists");

endmodule

`default_nettype wire
